// File: hdl/integer_to_radix_digits_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define ITRD_ASSERT_ALWAYS(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("assertion failed");

// A consequent that holds in the cycle after its antecedent.
`define ITRD_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/itrd_pkg.sv
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int WORD_W     = 64;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 2;
  localparam int REG_IDX_W  = 2;
  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int STEP_W     = $clog2(WORD_W);
  localparam int ALPHA_W    = 2 * WORD_W;

  localparam logic [REG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_32 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_64 = 2'd3;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [WORD_W-1:0]  ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [WORD_W-1:0]  ALPHA_HIGH_RESET = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic               done;
    logic               nonzero;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [DIGIT_W-1:0] digit;
  } digit_wr_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] last_addr;
  } emit_cmd_t;

endpackage

// File: hdl/itrd_if.sv
`timescale 1ns / 1ps

interface itrd_arg_if import itrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] raw_value;
  logic              is_signed;
  logic [MODE_W-1:0] width_mode;

  modport source (output valid, raw_value, is_signed, width_mode, input ready);
  modport sink (input valid, raw_value, is_signed, width_mode, output ready);
endinterface

interface itrd_text_if import itrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, digit_char, last_digit, input ready);
  modport sink (input valid, digit_char, last_digit, output ready);
endinterface

// File: hdl/itrd_divider.sv
`timescale 1ns / 1ps

module itrd_divider import itrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RADIX_W-1:0] base,
  input  logic [WORD_W-1:0]  dividend,
  output div_status_t        status,
  output logic [WORD_W-1:0]  quotient
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

  logic [WORD_W-1:0]  quo;
  logic [DIGIT_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;

  logic [RADIX_W-1:0] trial;
  logic               fits;
  logic [RADIX_W-1:0] trial_left;

  // One restoring step: bring down the next dividend bit and subtract the base if it fits.
  always_comb begin
    trial      = {rem, quo[WORD_W-1]};
    fits       = (trial >= base);
    trial_left = fits ? (trial - base) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      quo  <= {quo[WORD_W-2:0], fits};
      rem  <= trial_left[DIGIT_W-1:0];
      step <= step + 1'b1;
    end
  end

  assign quotient         = quo;
  assign status.done      = done;
  assign status.nonzero   = |quo;
  assign status.remainder = rem;

endmodule

// File: hdl/itrd_emitter.sv
`timescale 1ns / 1ps

module itrd_emitter import itrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  digit_wr_t          wr,
  input  emit_cmd_t          cmd,
  input  logic [ALPHA_W-1:0] alphabet,
  output logic               busy,
  itrd_text_if.source        text
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_READ = 2'd1;
  localparam logic [1:0] E_SHOW = 2'd2;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_digit;
  logic [ADDR_W-1:0]  ptr;
  logic [1:0]         state;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.digit;
    end
    if (state == E_READ) begin
      rd_digit <= mem[ptr];
    end
  end

  // Digits sit least significant first, so the readout walks the buffer downward.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (cmd.start) begin
            state <= E_READ;
          end
        end
        E_READ: begin
          state <= E_SHOW;
        end
        E_SHOW: begin
          if (text.ready) begin
            state <= (ptr == '0) ? E_IDLE : E_READ;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && cmd.start) begin
      ptr <= cmd.last_addr;
    end else if (state == E_SHOW && text.ready && ptr != '0) begin
      ptr <= ptr - 1'b1;
    end
  end

  assign busy            = (state != E_IDLE);
  assign text.valid      = (state == E_SHOW);
  assign text.digit_char = alphabet[{rd_digit, 3'b000} +: CHAR_W];
  assign text.last_digit = (ptr == '0);

endmodule

// File: hdl/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Channel   Role     Beat
// arg       sink     raw_value, is_signed, width_mode: one integer to convert
// text      source   digit_char, last_digit: one character, most significant first
// cfg_*     write    radix, alphabet_low, alphabet_high by index
//
// Each digit comes from the bit-serial divider (one quotient bit per cycle over the
// 64-bit word, plus the hand-off), and each character then passes through a read
// state and a show state in the readout from the digit buffer.
// A new item is taken only once the last character of the previous one has left.
// Reset is synchronous and restores the reset radix and alphabet; the digit
// buffer needs no clearing. A stall on text simply holds the current character.

module integer_to_radix_digits import itrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  itrd_arg_if.sink             arg,
  itrd_text_if.source          text
);

`include "integer_to_radix_digits_assert.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  logic [RADIX_W-1:0] radix;
  logic [WORD_W-1:0]  alphabet_low;
  logic [WORD_W-1:0]  alphabet_high;

  logic               state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_inc;

  logic [RADIX_W-1:0] base;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  top_bit;
  logic [WORD_W-1:0]  masked;
  logic [WORD_W-1:0]  magnitude;

  logic               arg_accept;
  logic               div_start;
  logic [WORD_W-1:0]  div_dividend;
  logic [WORD_W-1:0]  quotient;
  logic               more;
  logic               emit_busy;
  div_status_t        div_status;
  digit_wr_t          wr;
  emit_cmd_t          cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= RADIX_RESET;
      alphabet_low  <= ALPHA_LOW_RESET;
      alphabet_high <= ALPHA_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:      radix         <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHA_HIGH: alphabet_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  // Truncate to the selected width, then take the magnitude of a negative signed value.
  always_comb begin
    unique case (arg.width_mode)
      MODE_8:  mask = 64'h0000_0000_0000_00ff;
      MODE_16: mask = 64'h0000_0000_0000_ffff;
      MODE_32: mask = 64'h0000_0000_ffff_ffff;
      MODE_64: mask = 64'hffff_ffff_ffff_ffff;
      default: mask = 64'hffff_ffff_ffff_ffff;
    endcase
    top_bit = mask ^ (mask >> 1);
    masked  = arg.raw_value & mask;
    if (arg.is_signed && (masked & top_bit) != '0) begin
      magnitude = ~(masked | ~mask) + 1'b1;
    end else begin
      magnitude = masked;
    end
  end

  assign arg.ready  = (state == S_IDLE) && !emit_busy;
  assign arg_accept = arg.valid && arg.ready;
  assign count_inc  = count + 1'b1;
  assign more       = div_status.nonzero && (count_inc < CNT_W'(MAX_DIGITS));

  assign div_start    = arg_accept || (state == S_DIV && div_status.done && more);
  assign div_dividend = (state == S_IDLE) ? magnitude : quotient;

  assign wr.we         = (state == S_DIV) && div_status.done;
  assign wr.addr       = count[ADDR_W-1:0];
  assign wr.digit      = div_status.remainder;
  assign cmd.start     = wr.we && !more;
  assign cmd.last_addr = count[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (arg_accept) begin
            state <= S_DIV;
            count <= '0;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            if (more) begin
              count <= count_inc;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  itrd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .base     (base),
    .dividend (div_dividend),
    .status   (div_status),
    .quotient (quotient)
  );

  itrd_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .cmd      (cmd),
    .alphabet ({alphabet_high, alphabet_low}),
    .busy     (emit_busy),
    .text     (text)
  );

  // Input is held off while characters are still going out.
  `ITRD_ASSERT_ALWAYS(a_no_overlap, clk, rst, !(text.valid && arg.ready))
  // A finished division only ever arrives while the sequencer waits for it.
  `ITRD_ASSERT_ALWAYS(a_done_in_div, clk, rst, !div_status.done || state == S_DIV)
  // An accepted integer always starts a division.
  `ITRD_ASSERT_NEXT(a_accept_divides, clk, rst, arg_accept, state == S_DIV && !emit_busy)
  // Handing the digits over starts the readout.
  `ITRD_ASSERT_NEXT(a_handoff, clk, rst, cmd.start, emit_busy && state == S_IDLE)

endmodule

// File: sim/integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps

module integer_to_radix_digits_tb;
  import itrd_pkg::*;

  // Index 3 has no register behind it, so writes to it must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 14;
  localparam int STALL_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 38;
  localparam int CALM_PHASE    = 5;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } char_beat_t;

  class radix_text_board;
    logic [RADIX_W-1:0] radix;
    logic [WORD_W-1:0]  alpha_low;
    logic [WORD_W-1:0]  alpha_high;
    char_beat_t         pending_chars[$];
    int                 errors;
    int                 chars_seen;

    function new();
      radix      = RADIX_RESET;
      alpha_low  = ALPHA_LOW_RESET;
      alpha_high = ALPHA_HIGH_RESET;
      errors     = 0;
      chars_seen = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_RADIX:      radix = data[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha_low = data;
        REG_ALPHA_HIGH: alpha_high = data;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] char_of(logic [DIGIT_W-1:0] d);
      if (d[3])
        return alpha_high[d[2:0] * CHAR_W +: CHAR_W];
      return alpha_low[d[2:0] * CHAR_W +: CHAR_W];
    endfunction

    // Converts one accepted integer into the characters it must produce.
    function void add_integer(logic [WORD_W-1:0] raw, logic sgn, logic [MODE_W-1:0] mode);
      logic [WORD_W-1:0]  mask;
      logic [WORD_W-1:0]  mag;
      logic [WORD_W-1:0]  eff_radix;
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      int                 n;
      int                 k;
      char_beat_t         beat;
      case (mode)
        MODE_8:  mask = 64'h0000_0000_0000_00FF;
        MODE_16: mask = 64'h0000_0000_0000_FFFF;
        MODE_32: mask = 64'h0000_0000_FFFF_FFFF;
        default: mask = '1;
      endcase
      mag = raw & mask;
      // The sign bit is the top bit of the mask; the most negative value wraps
      // to its own magnitude, which is correct as an unsigned number.
      if (sgn && (mag & ~(mask >> 1)) != '0)
        mag = -(mag | ~mask);
      if (radix < RADIX_MIN)
        eff_radix = RADIX_MIN;
      else if (radix > RADIX_MAX)
        eff_radix = RADIX_MAX;
      else
        eff_radix = radix;
      n = 0;
      if (mag == '0) begin
        digits[0] = '0;
        n = 1;
      end else begin
        while (mag != '0 && n < MAX_DIGITS) begin
          digits[n] = DIGIT_W'(mag % eff_radix);
          mag = mag / eff_radix;
          n++;
        end
      end
      for (k = n - 1; k >= 0; k--) begin
        beat.digit_char = char_of(digits[k]);
        beat.last_digit = (k == 0);
        pending_chars.push_back(beat);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_LIMIT)
        $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_char(logic [CHAR_W-1:0] c, logic last);
      char_beat_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character #%0d 0x%02h last=%0b arrived with none pending",
                                  chars_seen, c, last));
        return;
      end
      want = pending_chars.pop_front();
      if (c !== want.digit_char)
        report_mismatch($sformatf("character #%0d digit_char 0x%02h, want 0x%02h",
                                  chars_seen, c, want.digit_char));
      if (last !== want.last_digit)
        report_mismatch($sformatf("character #%0d last_digit %0b, want %0b",
                                  chars_seen, last, want.last_digit));
    endtask

    task check_leftovers();
      if (pending_chars.size() != 0)
        report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  logic                 calm;
  int                   quiet_cycles = 0;
  radix_text_board      board;

  itrd_arg_if  arg_ch ();
  itrd_text_if text_ch ();

  integer_to_radix_digits uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .arg       (arg_ch),
    .text      (text_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    text_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Both channels are sampled here; the watchdog counts cycles without any beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (arg_ch.valid && arg_ch.ready)
        board.add_integer(arg_ch.raw_value, arg_ch.is_signed, arg_ch.width_mode);
      if (text_ch.valid && text_ch.ready)
        board.check_char(text_ch.digit_char, text_ch.last_digit);
      if ((arg_ch.valid && arg_ch.ready) || (text_ch.valid && text_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_integer(input logic [WORD_W-1:0] raw, input logic sgn,
                              input logic [MODE_W-1:0] mode);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      arg_ch.valid      <= 1'b0;
      arg_ch.raw_value  <= {$urandom, $urandom};
      arg_ch.is_signed  <= 1'($urandom_range(1));
      arg_ch.width_mode <= MODE_W'($urandom_range(3));
      @(negedge clk);
    end
    arg_ch.valid      <= 1'b1;
    arg_ch.raw_value  <= raw;
    arg_ch.is_signed  <= sgn;
    arg_ch.width_mode <= mode;
    @(posedge clk);
    while (!arg_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    arg_ch.valid <= 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] random_raw();
    logic [WORD_W-1:0] v;
    int                w;
    w = 8 << $urandom_range(3);
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(63);
      3: v = 64'($urandom_range(40));
      // Most negative value of a random width, with junk above the width.
      4: v = ({$urandom, $urandom} << w) | (64'd1 << (w - 1));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  initial begin
    logic [MODE_W-1:0]  modes [4];
    int                 widths [4];
    logic [RADIX_W-1:0] phase_radix [6];
    logic [WORD_W-1:0]  word;
    int                 i;
    int                 p;
    board  = new();
    modes  = '{MODE_8, MODE_16, MODE_32, MODE_64};
    widths = '{8, 16, 32, 64};
    // Extremes first, then the out-of-range radix values that must clamp.
    phase_radix = '{5'd16, 5'd2, 5'd0, 5'd1, 5'd31, 5'd17};
    calm              = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_RADIX;
    cfg_data          = '0;
    arg_ch.valid      = 1'b0;
    arg_ch.raw_value  = '0;
    arg_ch.is_signed  = 1'b0;
    arg_ch.width_mode = MODE_64;
    text_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset radix and alphabet.
    send_integer('0, 1'b0, MODE_64);
    send_integer('0, 1'b1, MODE_8);
    for (i = 0; i < 4; i++) begin
      send_integer('1, 1'b0, modes[i]);
      send_integer('1, 1'b1, modes[i]);
      send_integer(({$urandom, $urandom} << widths[i]) | (64'd1 << (widths[i] - 1)),
                   1'b1, modes[i]);
    end
    send_integer(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, MODE_64);
    send_integer(64'hFFFF_FFFF_FFFF_FF05, 1'b0, MODE_8);
    send_integer(64'h5A5A_5A5A_5A5A_A57F, 1'b1, MODE_8);
    send_integer(64'h0000_0000_0001_0001, 1'b1, MODE_16);

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      calm = (p == CALM_PHASE);
      word = {$urandom, $urandom};
      word[RADIX_W-1:0] = (p < 6) ? phase_radix[p] : RADIX_W'($urandom_range(3, 15));
      write_reg(REG_RADIX, word);
      if (p == 1) begin
        write_reg(REG_ALPHA_LOW, '0);
        write_reg(REG_ALPHA_HIGH, '1);
      end else if (p == 2) begin
        write_reg(REG_ALPHA_LOW, '1);
        write_reg(REG_ALPHA_HIGH, '0);
      end else begin
        write_reg(REG_ALPHA_LOW, {$urandom, $urandom});
        write_reg(REG_ALPHA_HIGH, {$urandom, $urandom});
      end
      if (p % 2 == 1)
        write_reg(REG_UNUSED, {$urandom, $urandom});
      repeat (PHASE_ITEMS)
        send_integer(random_raw(), 1'($urandom_range(1)), MODE_W'($urandom_range(3)));
    end

    calm = 1'b0;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.check_leftovers();
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: integer_to_radix_digits.f
+incdir+hdl
hdl/itrd_pkg.sv
hdl/itrd_if.sv
hdl/itrd_divider.sv
hdl/itrd_emitter.sv
hdl/integer_to_radix_digits.sv
sim/integer_to_radix_digits_tb.sv
